// File: hw/rtl/pla_pkg.sv
package pla_pkg;

    // Default number of list entries
    localparam int CAPACITY_DEF = 32;

    // Field widths of the request and result
    localparam int ACT_W   = 2;
    localparam int POS_W   = 6;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 6;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS  = 2'd2;

    // Broadcast control for every cell of the chain
    typedef struct packed {
        logic             ins;  // accepted insert that succeeds
        logic             del;  // accepted delete that succeeds
        logic [POS_W-1:0] idx;  // 0-based position of the request
    } cell_ctrl_t;

endpackage

// File: hw/rtl/pla_cell.sv
module pla_cell #(
    parameter int INDEX = 0
) (
    input  logic                           clk,
    input  pla_pkg::cell_ctrl_t            ctrl,
    input  logic [pla_pkg::DATA_W-1:0]     lower_data,
    input  logic [pla_pkg::DATA_W-1:0]     upper_data,
    input  logic [pla_pkg::DATA_W-1:0]     value,
    output logic [pla_pkg::DATA_W-1:0]     data,
    output logic [pla_pkg::DATA_W-1:0]     sel_data
);

    logic [pla_pkg::DATA_W-1:0] data_reg;
    logic [pla_pkg::DATA_W-1:0] data_next;
    logic                       match;
    logic                       above;

    // Compare own place with the request position
    assign match = (INDEX == int'(ctrl.idx));
    assign above = (INDEX > int'(ctrl.idx));

    // Load, take from a neighbor or hold
    always_comb
    begin
        priority if (ctrl.ins && match)
        begin
            data_next = value;
        end
        else if (ctrl.ins && above)
        begin
            data_next = lower_data;
        end
        else if (ctrl.del && (match || above))
        begin
            data_next = upper_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // Drive own entry onto the read bus only when addressed
    assign sel_data = match ? data_reg : '0;

endmodule

// File: hw/rtl/pla_chain.sv
module pla_chain #(
    parameter int CAPACITY = pla_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  pla_pkg::cell_ctrl_t            ctrl,
    input  logic [pla_pkg::DATA_W-1:0]     value,
    output logic [pla_pkg::DATA_W-1:0]     rd_data
);

    logic [pla_pkg::DATA_W-1:0] cell_data [CAPACITY];
    logic [pla_pkg::DATA_W-1:0] cell_sel  [CAPACITY];

    // Row of cells, each linked to its two neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [pla_pkg::DATA_W-1:0] lower;
        logic [pla_pkg::DATA_W-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = cell_data[i+1];
        end

        pla_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .lower_data (lower),
            .upper_data (upper),
            .value      (value),
            .data       (cell_data[i]),
            .sel_data   (cell_sel[i])
        );
    end

    // Merge the addressed entry onto the read bus
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_data = rd_data | cell_sel[i];
        end
    end

endmodule

// File: hw/rtl/positional_array_list.sv
// positional_array_list: ordered list of signed 32-bit elements.
// Request channel (req_valid / req_stall) carries action, position, value.
// action 0 reads, 1 inserts, 2 deletes at the 1-based position; any other
// code is refused. Result channel (res_valid / res_stall) carries status,
// element and count (list length after the request).
// A request is taken at an edge with req_valid high and req_stall low.
// Its result is registered in the output register at that edge, and one
// request is taken per cycle while results drain.
// Every entry sits in its own cell of a chain; an insert or delete moves
// all later entries one cell up or down in the same cycle, so the list
// length does not affect the rate.
// When the receiver stalls, the held result stays put and req_stall rises
// until it is taken; no request is lost.
// Reset empties the list and the output register; element storage is not
// cleared, since only positions 1..length are ever read.
module positional_array_list #(
    parameter int CAPACITY = pla_pkg::CAPACITY_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic        [pla_pkg::ACT_W-1:0]      action,
    input  logic        [pla_pkg::POS_W-1:0]      position,
    input  logic signed [pla_pkg::DATA_W-1:0]     value,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output logic        [pla_pkg::STAT_W-1:0]     status,
    output logic signed [pla_pkg::DATA_W-1:0]     element,
    output logic        [pla_pkg::COUNT_W-1:0]    count
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((LEN_W > pla_pkg::POS_W) ? LEN_W : pla_pkg::POS_W) + 1;

    logic [LEN_W-1:0]             len_reg;
    logic [LEN_W-1:0]             len_next;
    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic [pla_pkg::STAT_W-1:0]   status_reg;
    logic [pla_pkg::STAT_W-1:0]   status_next;
    logic [pla_pkg::DATA_W-1:0]   element_reg;
    logic [pla_pkg::DATA_W-1:0]   element_next;
    logic [pla_pkg::COUNT_W-1:0]  count_reg;

    logic                         take_req;
    logic [CMP_W-1:0]             pos_x;
    logic [CMP_W-1:0]             len_x;
    logic                         full;
    logic                         pos_in_list;
    logic                         pos_ins_ok;
    logic                         ins_ok;
    logic                         del_ok;
    logic [pla_pkg::DATA_W-1:0]   rd_data;
    pla_pkg::cell_ctrl_t          ctrl;

    // Accept while the output register is empty or being drained
    assign req_stall = res_valid_reg && res_stall;
    assign take_req  = req_valid && !req_stall;

    // Bounds checks against the current length
    assign pos_x       = CMP_W'(position);
    assign len_x       = CMP_W'(len_reg);
    assign full        = (len_reg == LEN_W'(CAPACITY));
    assign pos_in_list = (position != '0) && (pos_x <= len_x);
    assign pos_ins_ok  = (position != '0) && (pos_x <= len_x + CMP_W'(1));
    assign ins_ok      = (action == pla_pkg::ACT_INSERT) && !full && pos_ins_ok;
    assign del_ok      = (action == pla_pkg::ACT_DELETE) && pos_in_list;

    // Broadcast the shift command to the chain
    assign ctrl.ins = take_req && ins_ok;
    assign ctrl.del = take_req && del_ok;
    assign ctrl.idx = position - pla_pkg::POS_W'(1);

    pla_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .clk     (clk),
        .ctrl    (ctrl),
        .value   (value),
        .rd_data (rd_data)
    );

    // Decode the result and the new length
    always_comb
    begin
        status_next  = pla_pkg::ST_REFUSED;
        element_next = '0;
        len_next     = len_reg;
        unique case (action)
            pla_pkg::ACT_READ:
            begin
                if (pos_in_list)
                begin
                    status_next  = pla_pkg::ST_OK;
                    element_next = rd_data;
                end
            end
            pla_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = pla_pkg::ST_REFUSED;
                end
                else if (!pos_ins_ok)
                begin
                    status_next = pla_pkg::ST_BADPOS;
                end
                else
                begin
                    status_next = pla_pkg::ST_OK;
                    len_next    = len_reg + LEN_W'(1);
                end
            end
            pla_pkg::ACT_DELETE:
            begin
                if (pos_in_list)
                begin
                    status_next  = pla_pkg::ST_OK;
                    element_next = rd_data;
                    len_next     = len_reg - LEN_W'(1);
                end
            end
            default:
            begin
                status_next = pla_pkg::ST_REFUSED;
            end
        endcase
    end

    // Output register valid: set on a request, drop once taken
    always_comb
    begin
        priority if (take_req)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take_req)
            begin
                len_reg <= len_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            status_reg  <= status_next;
            element_reg <= element_next;
            count_reg   <= pla_pkg::COUNT_W'(len_next);
        end
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign count     = count_reg;

    // Length never passes the capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("list length beyond capacity");

    // A successful insert grows the list by one
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (take_req && ins_ok) |=> (len_reg == $past(len_reg) + LEN_W'(1)))
        else $error("insert did not grow the list");

    // A successful delete shrinks the list by one
    a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (take_req && del_ok) |=> (len_reg == $past(len_reg) - LEN_W'(1)))
        else $error("delete did not shrink the list");

    // A result that is not ok carries no element
    a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (status_reg != pla_pkg::ST_OK)) |-> (element_reg == '0))
        else $error("element set on a refused request");

    // Reported count matches the stored length
    a_count_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (count_reg == pla_pkg::COUNT_W'(len_reg)))
        else $error("count differs from list length");

endmodule

// File: test/tb_positional_array_list.sv
`timescale 1ns / 100ps

module tb_positional_array_list;

    localparam int CAPACITY = pla_pkg::CAPACITY_DEF;

    // Action code outside the defined set; the block refuses it
    localparam logic [pla_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 120;
    localparam int PHASES         = 11;
    localparam int PHASE_ITEMS    = 100;

    typedef struct packed {
        logic [pla_pkg::STAT_W-1:0]  st;
        logic [pla_pkg::DATA_W-1:0]  el;
        logic [pla_pkg::COUNT_W-1:0] cnt;
    } list_result_t;

    // Shadow list: predicts each result and checks what the block returns
    class list_scoreboard;
        logic [pla_pkg::DATA_W-1:0] entries [CAPACITY];
        int                         length = 0;
        int                         errors = 0;
        list_result_t               pending [$];

        function void note_request(input logic [pla_pkg::ACT_W-1:0] act,
                                   input logic [pla_pkg::POS_W-1:0] pos,
                                   input logic [pla_pkg::DATA_W-1:0] val);
            list_result_t r;
            int           p;
            int           i;
            p    = int'(pos);
            r.st = pla_pkg::ST_REFUSED;
            r.el = '0;
            case (act)
                pla_pkg::ACT_READ:
                    if (p >= 1 && p <= length) begin
                        r.el = entries[p-1];
                        r.st = pla_pkg::ST_OK;
                    end
                pla_pkg::ACT_INSERT:
                    if (length >= CAPACITY) begin
                        r.st = pla_pkg::ST_REFUSED;
                    end else if (p < 1 || p > length + 1) begin
                        r.st = pla_pkg::ST_BADPOS;
                    end else begin
                        // open a slot at the position
                        for (i = length; i >= p; i--)
                            entries[i] = entries[i-1];
                        entries[p-1] = val;
                        length++;
                        r.st = pla_pkg::ST_OK;
                    end
                pla_pkg::ACT_DELETE:
                    if (p >= 1 && p <= length) begin
                        r.el = entries[p-1];
                        // close the gap
                        for (i = p; i < length; i++)
                            entries[i-1] = entries[i];
                        length--;
                        r.st = pla_pkg::ST_OK;
                    end
                default: ;
            endcase
            r.cnt = length[pla_pkg::COUNT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(input logic [pla_pkg::STAT_W-1:0] st,
                                   input logic [pla_pkg::DATA_W-1:0] el,
                                   input logic [pla_pkg::COUNT_W-1:0] cnt);
            list_result_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: result with none pending: status %0d element %0d count %0d",
                         $time, st, $signed(el), cnt);
                errors++;
            end else begin
                exp_r = pending.pop_front();
                if (st !== exp_r.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.st, st);
                    errors++;
                end
                if (el !== exp_r.el) begin
                    $display("%0t: element expected %0d actual %0d",
                             $time, $signed(exp_r.el), $signed(el));
                    errors++;
                end
                if (cnt !== exp_r.cnt) begin
                    $display("%0t: count expected %0d actual %0d", $time, exp_r.cnt, cnt);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                req_valid = 1'b0;
    logic                                req_stall;
    logic        [pla_pkg::ACT_W-1:0]    action    = pla_pkg::ACT_READ;
    logic        [pla_pkg::POS_W-1:0]    position  = '0;
    logic signed [pla_pkg::DATA_W-1:0]   value     = '0;
    logic                                res_valid;
    logic                                res_stall = 1'b0;
    logic        [pla_pkg::STAT_W-1:0]   status;
    logic signed [pla_pkg::DATA_W-1:0]   element;
    logic        [pla_pkg::COUNT_W-1:0]  count;

    list_scoreboard sb = new;

    int idle_odds = 0;
    bit hold_off  = 1'b0;
    int quiet_cycles = 0;

    positional_array_list #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .action    (action),
        .position  (position),
        .value     (value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .element   (element),
        .count     (count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check results before noting the request taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (res_valid && !res_stall)
                sb.check_result(status, element, count);
            if (req_valid && !req_stall)
                sb.note_request(action, position, value);
            if ((res_valid && !res_stall) || (req_valid && !req_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Offer one request, hold it until taken, then maybe drop valid for a while
    task automatic send_request(input logic [pla_pkg::ACT_W-1:0] act,
                                input logic [pla_pkg::POS_W-1:0] pos,
                                input logic [pla_pkg::DATA_W-1:0] val);
        req_valid <= 1'b1;
        action    <= act;
        position  <= pos;
        value     <= val;
        do
            @(posedge clk);
        while (req_stall);
        if ($urandom_range(0, 99) < idle_odds) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_off) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
                hold_off = 1'b0;
            end else if ($urandom_range(0, 99) < idle_odds) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int                           ph;
        int                           k;
        int                           r;
        int                           q;
        int                           len;
        int                           ins_pct;
        int                           del_pct;
        logic [pla_pkg::ACT_W-1:0]    act;
        logic [pla_pkg::POS_W-1:0]    pos;
        logic [pla_pkg::DATA_W-1:0]   val;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, bad positions, ends and middle, unused action
        idle_odds = 15;
        send_request(pla_pkg::ACT_READ,   6'd1,  32'd0);
        send_request(pla_pkg::ACT_DELETE, 6'd1,  32'd0);
        send_request(pla_pkg::ACT_INSERT, 6'd0,  32'd5);
        send_request(pla_pkg::ACT_INSERT, 6'd2,  32'd5);
        send_request(ACT_UNUSED,          6'd1,  32'd7);
        send_request(pla_pkg::ACT_INSERT, 6'd1,  32'h7FFFFFFF);
        send_request(pla_pkg::ACT_INSERT, 6'd1,  32'h80000000);
        send_request(pla_pkg::ACT_INSERT, 6'd3,  32'hFFFFFFFF);
        send_request(pla_pkg::ACT_INSERT, 6'd2,  32'd0);
        send_request(pla_pkg::ACT_READ,   6'd1,  32'd0);
        send_request(pla_pkg::ACT_READ,   6'd4,  32'd0);
        send_request(pla_pkg::ACT_READ,   6'd5,  32'd0);
        send_request(pla_pkg::ACT_READ,   6'd63, 32'd0);
        send_request(pla_pkg::ACT_READ,   6'd0,  32'd0);
        send_request(pla_pkg::ACT_DELETE, 6'd0,  32'd0);
        send_request(pla_pkg::ACT_DELETE, 6'd63, 32'd0);
        send_request(pla_pkg::ACT_DELETE, 6'd5,  32'd0);
        send_request(pla_pkg::ACT_DELETE, 6'd2,  32'd0);
        send_request(pla_pkg::ACT_DELETE, 6'd3,  32'd0);
        send_request(ACT_UNUSED,          6'd63, 32'hFFFFFFFF);
        send_request(pla_pkg::ACT_DELETE, 6'd1,  32'd0);
        send_request(pla_pkg::ACT_INSERT, 6'd63, 32'd9);
        send_request(pla_pkg::ACT_READ,   6'd1,  32'd0);
        send_request(pla_pkg::ACT_DELETE, 6'd1,  32'd0);

        // Random phases, insert-heavy, mixed and delete-heavy in turn
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph >= PHASES - 2)
                idle_odds = 0;
            else
                idle_odds = (ph % 2 == 0) ? 20 : 0;
            if (ph == 4)
                hold_off = 1'b1;
            case (ph % 3)
                0:       begin ins_pct = 65; del_pct = 20; end
                1:       begin ins_pct = 40; del_pct = 40; end
                default: begin ins_pct = 20; del_pct = 65; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                len = sb.length;
                r = $urandom_range(0, 99);
                if (r < 2)
                    act = ACT_UNUSED;
                else if (r < 2 + ins_pct)
                    act = pla_pkg::ACT_INSERT;
                else if (r < 2 + ins_pct + del_pct)
                    act = pla_pkg::ACT_DELETE;
                else
                    act = pla_pkg::ACT_READ;

                // mostly legal positions, with edges and anything at all now and then
                q = $urandom_range(0, 9);
                if (q == 0)
                    pos = pla_pkg::POS_W'($urandom_range(0, 63));
                else if (q == 1)
                    pos = pla_pkg::POS_W'((act == pla_pkg::ACT_INSERT) ? len + 1 : len);
                else if (q == 2)
                    pos = pla_pkg::POS_W'(1);
                else if (act == pla_pkg::ACT_INSERT)
                    pos = pla_pkg::POS_W'($urandom_range(1, len + 1));
                else
                    pos = pla_pkg::POS_W'($urandom_range(1, (len > 0) ? len : 1));

                case ($urandom_range(0, 19))
                    0:       val = 32'h80000000;
                    1:       val = 32'h7FFFFFFF;
                    2:       val = 32'h00000000;
                    3:       val = 32'hFFFFFFFF;
                    default: val = $urandom;
                endcase
                send_request(act, pos, val);
            end
        end
        req_valid <= 1'b0;

        // Drain outstanding results before the final report
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
